@@ hw/rtl/mmc_pkg.sv @@
// ----------------------------------------------------------------------------
// mmc_pkg
// shared types, constants and control store for the magic multiplier check
// ----------------------------------------------------------------------------
package mmc_pkg;

	localparam int INDEX_BITS_DEF = 9;
	localparam int MAGIC_W        = 64;
	localparam int STATUS_W       = 2;
	localparam int COUNT_W        = 10;
	localparam int EPOCH_W        = 4;
	localparam int STEP_W         = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_COLLISION = 2'd1,
		ST_TOO_WIDE  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_CLEAR_PEND,
		JC_NO_REQ,
		JC_TOO_WIDE,
		JC_NOT_DONE,
		JC_CLR_NOT_DONE,
		JC_OUT_BUSY
	} jcond_t;

	localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
	localparam logic [STEP_W-1:0] STEP_ACCEPT = 3'd1;
	localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_RUN    = 3'd4;
	localparam logic [STEP_W-1:0] STEP_REPORT = 3'd5;
	localparam logic [STEP_W-1:0] STEP_LOOP   = 3'd6;
	localparam logic [STEP_W-1:0] STEP_CLEAR  = 3'd7;

	typedef struct packed {
		logic accept;
		logic load;
		logic start;
		logic report;
		logic clear;
	} ctrl_t;

	typedef struct packed {
		logic clear_pend;
		logic req_valid;
		logic too_wide;
		logic run_done;
		logic clr_done;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		ctrl_t             act;
		jcond_t            cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	localparam ctrl_t ACT_NONE = '{accept: 1'b0, load: 1'b0, start: 1'b0,
		report: 1'b0, clear: 1'b0};

	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
		uword_t w;
		w = '{act: ACT_NONE, cond: JC_NEVER, target: STEP_WAIT};
		unique case (addr)
			STEP_WAIT: begin
				w.cond   = JC_CLEAR_PEND;
				w.target = STEP_CLEAR;
			end
			STEP_ACCEPT: begin
				w.act.accept = 1'b1;
				w.cond       = JC_NO_REQ;
				w.target     = STEP_WAIT;
			end
			STEP_LOAD: begin
				w.act.load = 1'b1;
			end
			STEP_CHECK: begin
				w.act.start = 1'b1;
				w.cond      = JC_TOO_WIDE;
				w.target    = STEP_REPORT;
			end
			STEP_RUN: begin
				w.cond   = JC_NOT_DONE;
				w.target = STEP_RUN;
			end
			STEP_REPORT: begin
				w.act.report = 1'b1;
				w.cond       = JC_OUT_BUSY;
				w.target     = STEP_REPORT;
			end
			STEP_LOOP: begin
				w.cond   = JC_ALWAYS;
				w.target = STEP_WAIT;
			end
			STEP_CLEAR: begin
				w.act.clear = 1'b1;
				w.cond      = JC_CLR_NOT_DONE;
				w.target    = STEP_CLEAR;
			end
			default: begin
				w.cond   = JC_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/mmc_if.sv @@
// ----------------------------------------------------------------------------
// mmc_if
// valid/ready channels for candidate requests and check results
// ----------------------------------------------------------------------------
interface mmc_cand_if;
	logic                         valid;
	logic                         ready;
	logic [mmc_pkg::MAGIC_W-1:0]  candidate_magic;

	modport source (output valid, output candidate_magic, input ready);
	modport sink (input valid, input candidate_magic, output ready);
endinterface

interface mmc_result_if;
	logic                         valid;
	logic                         ready;
	logic [mmc_pkg::STATUS_W-1:0] status;
	logic [mmc_pkg::COUNT_W-1:0]  subsets_checked;

	modport source (output valid, output status, output subsets_checked, input ready);
	modport sink (input valid, input status, input subsets_checked, output ready);
endinterface

@@ hw/rtl/mmc_seq.sv @@
// ----------------------------------------------------------------------------
// mmc_seq
// step counter and control store with conditional jumps
// ----------------------------------------------------------------------------
module mmc_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  mmc_pkg::stat_t stat,
	output mmc_pkg::ctrl_t ctrl
);

	logic [mmc_pkg::STEP_W-1:0] step_q;
	mmc_pkg::uword_t            uw;
	logic                       take;

	assign uw   = mmc_pkg::ucode_rom(step_q);
	assign ctrl = uw.act;

	always_comb begin
		unique case (uw.cond)
			mmc_pkg::JC_NEVER:        take = 1'b0;
			mmc_pkg::JC_ALWAYS:       take = 1'b1;
			mmc_pkg::JC_CLEAR_PEND:   take = stat.clear_pend;
			mmc_pkg::JC_NO_REQ:       take = !stat.req_valid;
			mmc_pkg::JC_TOO_WIDE:     take = stat.too_wide;
			mmc_pkg::JC_NOT_DONE:     take = !stat.run_done;
			mmc_pkg::JC_CLR_NOT_DONE: take = !stat.clr_done;
			mmc_pkg::JC_OUT_BUSY:     take = stat.out_busy;
			default:                  take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mmc_pkg::STEP_WAIT;
		end else if (take) begin
			step_q <= uw.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

@@ hw/rtl/mmc_datapath.sv @@
// ----------------------------------------------------------------------------
// mmc_datapath
// subset walker, split multiplier pipeline, epoch-tagged index map, result
// ----------------------------------------------------------------------------
module mmc_datapath #(
	parameter int INDEX_BITS = mmc_pkg::INDEX_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mmc_pkg::MAGIC_W-1:0]  cfg_wr_data,
	input  logic                         cand_valid,
	input  logic [mmc_pkg::MAGIC_W-1:0]  cand_magic,
	input  mmc_pkg::ctrl_t               ctrl,
	output mmc_pkg::stat_t               stat,
	input  logic                         res_ready,
	output logic                         res_valid,
	output logic [mmc_pkg::STATUS_W-1:0] res_status,
	output logic [mmc_pkg::COUNT_W-1:0]  res_count
);

	localparam int MAP_DEPTH = 1 << INDEX_BITS;
	localparam int CNT_W     = INDEX_BITS + 1;
	localparam int EPOCH_W   = mmc_pkg::EPOCH_W;

	logic [mmc_pkg::MAGIC_W-1:0] mask_q;
	logic [mmc_pkg::MAGIC_W-1:0] magic_q;
	logic                        too_wide_q;
	logic [EPOCH_W-1:0]          epoch_q;
	logic [INDEX_BITS-1:0]       clr_addr_q;

	logic                        gen_on_q;
	logic [mmc_pkg::MAGIC_W-1:0] sub_q;
	logic [mmc_pkg::MAGIC_W-1:0] sub_next;
	logic                        sub_last;

	logic                        v_s1, v_s2, v_s3;
	logic                        last_s1, last_s2, last_s3;
	logic [31:0]                 ll_hi_s1, lh_s1, hl_s1;
	logic [INDEX_BITS-1:0]       idx_s2, idx_s3;
	logic [EPOCH_W-1:0]          tag_s3;

	logic                        wv_q;
	logic [INDEX_BITS-1:0]       widx_q;
	logic                        done_q;
	logic                        coll_q;
	logic [CNT_W-1:0]            count_q;

	logic                        out_valid_q;
	logic [mmc_pkg::STATUS_W-1:0] out_status_q;
	logic [mmc_pkg::COUNT_W-1:0] out_count_q;

	logic [63:0]                 pp_ll;
	logic [31:0]                 pp_lh, pp_hl;
	logic [31:0]                 top_sum;
	logic                        hit;
	logic                        fin;
	logic                        out_busy;
	logic                        rpt_fire;
	logic                        clr_done;
	logic                        wide_now;
	logic [CNT_W+9:0]            cnt_ext;
	mmc_pkg::status_t            res_code;

	logic [EPOCH_W-1:0]          map_q [MAP_DEPTH];

	// carry-rippler subset step
	assign sub_next = (sub_q - mask_q) & mask_q;
	assign sub_last = (sub_next == '0);

	// low 64 bits of the product, only the upper word is needed
	assign pp_ll   = sub_q[31:0] * magic_q[31:0];
	assign pp_lh   = sub_q[31:0] * magic_q[63:32];
	assign pp_hl   = sub_q[63:32] * magic_q[31:0];
	assign top_sum = ll_hi_s1 + lh_s1 + hl_s1;

	// previous write lands on the same edge as this read, so forward it
	assign hit      = (tag_s3 == epoch_q) || (wv_q && (widx_q == idx_s3));
	assign fin      = v_s3 && (hit || last_s3);
	assign out_busy = out_valid_q && !res_ready;
	assign rpt_fire = ctrl.report && !out_busy;
	assign clr_done = (clr_addr_q == INDEX_BITS'(MAP_DEPTH - 1));
	assign wide_now = ($countones(mask_q) > INDEX_BITS);
	assign cnt_ext  = {10'd0, count_q};

	always_comb begin
		if (too_wide_q) begin
			res_code = mmc_pkg::ST_TOO_WIDE;
		end else if (coll_q) begin
			res_code = mmc_pkg::ST_COLLISION;
		end else begin
			res_code = mmc_pkg::ST_OK;
		end
	end

	assign stat.clear_pend = (epoch_q == '0);
	assign stat.req_valid  = cand_valid;
	assign stat.too_wide   = too_wide_q;
	assign stat.run_done   = done_q;
	assign stat.clr_done   = clr_done;
	assign stat.out_busy   = out_busy;

	assign res_valid  = out_valid_q;
	assign res_status = out_status_q;
	assign res_count  = out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			too_wide_q  <= 1'b0;
			epoch_q     <= '0;
			clr_addr_q  <= '0;
			gen_on_q    <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			wv_q        <= 1'b0;
			done_q      <= 1'b0;
			coll_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mask_q <= cfg_wr_data;
			end
			if (ctrl.load) begin
				too_wide_q <= wide_now;
				done_q     <= 1'b0;
				coll_q     <= 1'b0;
				count_q    <= '0;
			end else begin
				if (v_s3) begin
					count_q <= count_q + 1'b1;
				end
				if (fin) begin
					done_q <= 1'b1;
					coll_q <= hit;
				end
			end
			if (ctrl.start && !too_wide_q) begin
				gen_on_q <= 1'b1;
			end else if (gen_on_q && (fin || sub_last)) begin
				gen_on_q <= 1'b0;
			end
			v_s1 <= gen_on_q && !fin;
			v_s2 <= v_s1 && !fin;
			v_s3 <= v_s2 && !fin;
			wv_q <= v_s3 && !fin;
			if (ctrl.clear) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (ctrl.clear && clr_done) begin
				epoch_q <= EPOCH_W'(1);
			end else if (rpt_fire) begin
				epoch_q <= epoch_q + 1'b1;
			end
			if (rpt_fire) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept && cand_valid) begin
			magic_q <= cand_magic;
		end
		if (ctrl.load) begin
			sub_q <= '0;
		end else if (gen_on_q) begin
			sub_q <= sub_next;
		end
		ll_hi_s1 <= pp_ll[63:32];
		lh_s1    <= pp_lh;
		hl_s1    <= pp_hl;
		last_s1  <= sub_last;
		idx_s2   <= top_sum[31 -: INDEX_BITS];
		last_s2  <= last_s1;
		idx_s3   <= idx_s2;
		last_s3  <= last_s2;
		widx_q   <= idx_s3;
		if (rpt_fire) begin
			out_status_q <= res_code;
			out_count_q  <= cnt_ext[9:0];
		end
	end

	always_ff @(posedge clk) begin
		tag_s3 <= map_q[idx_s2];
		if (ctrl.clear) begin
			map_q[clr_addr_q] <= '0;
		end else if (v_s3) begin
			map_q[idx_s3] <= epoch_q;
		end
	end

endmodule

@@ hw/rtl/magic_multiplier_collision_check.sv @@
// ----------------------------------------------------------------------------
// magic_multiplier_collision_check
// tests candidate multipliers for index collisions over all mask subsets
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  cand      in   valid / ready    candidate_magic[63:0]
//  result    out  valid / ready    status[1:0], subsets_checked[9:0]
//  cfg       in   cfg_wr_en        cfg_wr_data[63:0] (occupancy mask)
//
//  a request with k mask bits set, k <= INDEX_BITS, is reported before
//  the next accept; the subset walk hashes one subset per cycle through
//  a 3-stage multiplier and map pipeline, ending early on a collision;
//  too wide masks skip the subset walk. the index map uses 4-bit epoch
//  tags: a clearing pass over all 2^INDEX_BITS map entries runs after
//  reset and after every 15 requests, with cand.ready low. the result register
//  frees the sequencer unless still unaccepted when the next result is due.
// ----------------------------------------------------------------------------
module magic_multiplier_collision_check #(
	parameter int INDEX_BITS = mmc_pkg::INDEX_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [mmc_pkg::MAGIC_W-1:0] cfg_wr_data,
	mmc_cand_if.sink                    cand,
	mmc_result_if.source                result
);

	mmc_pkg::ctrl_t ctrl;
	mmc_pkg::stat_t stat;

	assign cand.ready = ctrl.accept;

	mmc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	mmc_datapath #(
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cand_valid  (cand.valid),
		.cand_magic  (cand.candidate_magic),
		.ctrl        (ctrl),
		.stat        (stat),
		.res_ready   (result.ready),
		.res_valid   (result.valid),
		.res_status  (result.status),
		.res_count   (result.subsets_checked)
	);

endmodule

@@ hw/rtl/mmc_checker.sv @@
// ----------------------------------------------------------------------------
// mmc_checker
// port-level assertions for the magic multiplier check, bound to the top
// ----------------------------------------------------------------------------
module mmc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cand_valid,
	input logic                         cand_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [mmc_pkg::STATUS_W-1:0] res_status,
	input logic [mmc_pkg::COUNT_W-1:0]  res_count
);

	// one request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cand_valid && cand_ready |=> !cand_ready)
		else $error("request accepted on two consecutive cycles");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			res_valid && $stable(res_status) && $stable(res_count))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == mmc_pkg::ST_OK) ||
			(res_status == mmc_pkg::ST_COLLISION) ||
			(res_status == mmc_pkg::ST_TOO_WIDE))
		else $error("undefined status code");

	// too wide hashes nothing
	a_too_wide_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == mmc_pkg::ST_TOO_WIDE) |-> (res_count == '0))
		else $error("too wide result with nonzero count");

endmodule

bind magic_multiplier_collision_check mmc_checker u_mmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cand_valid (cand.valid),
	.cand_ready (cand.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_status (result.status),
	.res_count  (result.subsets_checked)
);
